### hw/rtl/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int CP_BITS = 21;
  localparam int OUT_COUNT_BITS = 16;

  // Lead-byte classes that the front end assigns to each incoming byte.
  localparam logic [1:0] KIND_END   = 2'd0;
  localparam logic [1:0] KIND_ASCII = 2'd1;
  localparam logic [1:0] KIND_LEAD  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] len;
    logic [6:0] lead;
    logic [5:0] cont;
  } item_t;

  typedef struct packed {
    logic [CP_BITS-1:0]        code_point;
    logic                      is_error;
    logic                      is_end;
    logic [OUT_COUNT_BITS-1:0] char_count;
  } result_t;

endpackage

### hw/rtl/u8d_fifo.sv
`timescale 1ns / 1ps

module u8d_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/u8d_front.sv
`timescale 1ns / 1ps

module u8d_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     in_byte,
  output logic           full,
  output logic           item_valid,
  input  logic           item_ready,
  output u8d_pkg::item_t item
);

  u8d_pkg::item_t cls;
  logic           fifo_empty;

  // Each byte is classified as if it were a lead byte; the back end decides
  // whether it is really a continuation byte.
  always_comb begin
    cls.kind = u8d_pkg::KIND_BAD;
    cls.len  = 2'd0;
    cls.lead = in_byte[6:0];
    cls.cont = in_byte[5:0];
    if (in_byte == 8'd0) begin
      cls.kind = u8d_pkg::KIND_END;
    end else if (!in_byte[7]) begin
      cls.kind = u8d_pkg::KIND_ASCII;
    end else if (!in_byte[5]) begin
      cls.kind = u8d_pkg::KIND_LEAD;
      cls.len  = 2'd1;
      cls.lead = {2'b00, in_byte[4:0]};
    end else if (!in_byte[4]) begin
      cls.kind = u8d_pkg::KIND_LEAD;
      cls.len  = 2'd2;
      cls.lead = {3'b000, in_byte[3:0]};
    end else if (!in_byte[3]) begin
      cls.kind = u8d_pkg::KIND_LEAD;
      cls.len  = 2'd3;
      cls.lead = {4'b0000, in_byte[2:0]};
    end
  end

  assign item_valid = !fifo_empty;

  u8d_fifo #(
    .WIDTH($bits(u8d_pkg::item_t))
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (cls),
    .full    (full),
    .rd_en   (item_ready && !fifo_empty),
    .rd_data (item),
    .empty   (fifo_empty)
  );

endmodule

### hw/rtl/u8d_back.sv
`timescale 1ns / 1ps

module u8d_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  input  u8d_pkg::item_t                     item,
  output logic                               item_ready,
  input  logic                               pop,
  output logic                               empty,
  output logic [u8d_pkg::CP_BITS-1:0]        code_point,
  output logic                               is_error,
  output logic                               is_end,
  output logic [u8d_pkg::OUT_COUNT_BITS-1:0] char_count
);

  logic [u8d_pkg::CP_BITS-1:0] partial_value;
  logic [u8d_pkg::CP_BITS-1:0] partial_value_next;
  logic [1:0]                  bytes_pending;
  logic [1:0]                  bytes_pending_next;
  logic [COUNT_BITS-1:0]       decoded_count;
  logic [COUNT_BITS-1:0]       decoded_count_next;
  logic                        skip_to_end;
  logic                        skip_to_end_next;

  logic                                   take;
  logic                                   res_full;
  logic                                   res_wr;
  logic [COUNT_BITS-1:0]                  count_bumped;
  logic [COUNT_BITS+u8d_pkg::OUT_COUNT_BITS-1:0] count_wide;
  logic [u8d_pkg::CP_BITS-1:0]            gathered;
  u8d_pkg::result_t                       res;
  u8d_pkg::result_t                       res_head;

  assign item_ready = !res_full;
  assign take       = item_valid && item_ready;

  // The count saturates at its all-ones value.
  assign count_bumped = (decoded_count == {COUNT_BITS{1'b1}}) ?
                        decoded_count : decoded_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
  assign gathered     = {partial_value[u8d_pkg::CP_BITS-7:0], item.cont};

  always_comb begin
    partial_value_next = partial_value;
    bytes_pending_next = bytes_pending;
    decoded_count_next = decoded_count;
    skip_to_end_next   = skip_to_end;
    res_wr             = 1'b0;
    res.code_point     = '0;
    res.is_error       = 1'b0;
    res.is_end         = 1'b0;
    count_wide         = '0;
    if (take) begin
      if (item.kind == u8d_pkg::KIND_END) begin
        res_wr             = 1'b1;
        res.is_end         = 1'b1;
        res.is_error       = !skip_to_end && (bytes_pending != 2'd0);
        count_wide         = {{u8d_pkg::OUT_COUNT_BITS{1'b0}}, decoded_count};
        partial_value_next = '0;
        bytes_pending_next = 2'd0;
        decoded_count_next = '0;
        skip_to_end_next   = 1'b0;
      end else if (skip_to_end) begin
        res_wr = 1'b0;
      end else if (bytes_pending != 2'd0) begin
        bytes_pending_next = bytes_pending - 2'd1;
        if (bytes_pending == 2'd1) begin
          res_wr             = 1'b1;
          res.code_point     = gathered;
          count_wide         = {{u8d_pkg::OUT_COUNT_BITS{1'b0}}, count_bumped};
          decoded_count_next = count_bumped;
          partial_value_next = '0;
        end else begin
          partial_value_next = gathered;
        end
      end else begin
        case (item.kind)
          u8d_pkg::KIND_ASCII: begin
            res_wr             = 1'b1;
            res.code_point     = {{(u8d_pkg::CP_BITS-7){1'b0}}, item.lead};
            count_wide         = {{u8d_pkg::OUT_COUNT_BITS{1'b0}}, count_bumped};
            decoded_count_next = count_bumped;
          end
          u8d_pkg::KIND_LEAD: begin
            partial_value_next = {{(u8d_pkg::CP_BITS-7){1'b0}}, item.lead};
            bytes_pending_next = item.len;
          end
          default: begin
            res_wr             = 1'b1;
            res.is_error       = 1'b1;
            count_wide         = {{u8d_pkg::OUT_COUNT_BITS{1'b0}}, decoded_count};
            skip_to_end_next   = 1'b1;
            partial_value_next = '0;
          end
        endcase
      end
    end
    res.char_count = count_wide[u8d_pkg::OUT_COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_pending <= 2'd0;
      decoded_count <= '0;
      skip_to_end   <= 1'b0;
    end else begin
      partial_value <= partial_value_next;
      bytes_pending <= bytes_pending_next;
      decoded_count <= decoded_count_next;
      skip_to_end   <= skip_to_end_next;
    end
  end

  u8d_fifo #(
    .WIDTH($bits(u8d_pkg::result_t))
  ) u_results (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop && !empty),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign code_point = res_head.code_point;
  assign is_error   = res_head.is_error;
  assign is_end     = res_head.is_end;
  assign char_count = res_head.char_count;

`ifndef NO_ASSERTIONS
  a_no_pending_while_skipping: assert property (@(posedge clk) disable iff (rst)
    !(skip_to_end && bytes_pending != 2'd0))
    else $error("continuation bytes pending while skipping to terminator");

  a_partial_clear_when_idle: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending == 2'd0) |-> (partial_value == '0))
    else $error("partial value left over outside a sequence");

  a_end_clears_state: assert property (@(posedge clk) disable iff (rst)
    (take && item.kind == u8d_pkg::KIND_END) |=>
      (decoded_count == '0 && bytes_pending == 2'd0 && !skip_to_end))
    else $error("terminator did not clear string state");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !(take && item.kind == u8d_pkg::KIND_END) |=> (decoded_count >= $past(decoded_count)))
    else $error("character count went down without a terminator");
`endif

endmodule

### hw/rtl/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps

// UTF-8 stream decoder. Push one byte per request; each decoded character,
// each invalid lead byte (1x111xxx) and each terminating zero byte yields
// one result, while lead and middle bytes of a sequence yield none. After an
// invalid lead, bytes are dropped until the zero byte. The block takes one
// byte every clock cycle as long as results are popped. A byte accepted at
// a clock edge is stored in the two-entry queue after the classifying front
// end and is decoded from there once the result queue has room; its result
// goes into the two-entry result queue, which reads out without a register
// stage, and it is popped from there.
module utf8_stream_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic [7:0]                         in_byte,
  output logic                               full,
  input  logic                               pop,
  output logic                               empty,
  output logic [u8d_pkg::CP_BITS-1:0]        code_point,
  output logic                               is_error,
  output logic                               is_end,
  output logic [u8d_pkg::OUT_COUNT_BITS-1:0] char_count
);

  u8d_pkg::item_t item;
  logic           item_valid;
  logic           item_ready;

  u8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_byte    (in_byte),
    .full       (full),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  u8d_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready),
    .pop        (pop),
    .empty      (empty),
    .code_point (code_point),
    .is_error   (is_error),
    .is_end     (is_end),
    .char_count (char_count)
  );

endmodule

### verif/utf8_stream_decoder_unit_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_tb;

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam int CYCLE_LIMIT = 40000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_BYTES = 190;
  localparam int DIRECTED_BYTES = 35;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic full;
  logic pop = 1'b0;
  logic empty;
  logic [u8d_pkg::CP_BITS-1:0] code_point;
  logic is_error;
  logic is_end;
  logic [u8d_pkg::OUT_COUNT_BITS-1:0] char_count;

  logic [7:0] pend_q[$];
  u8d_pkg::result_t decoded_q[$];

  // Decoder state as the byte stream is accepted.
  logic [u8d_pkg::CP_BITS-1:0] dec_partial = '0;
  logic [1:0] dec_pending = '0;
  logic [COUNT_BITS-1:0] dec_count = '0;
  logic dec_skip = 1'b0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int errors = 0;
  int cycles = 0;
  int gen_count = 0;

  utf8_stream_decoder_unit #(
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .in_byte(in_byte),
    .full(full),
    .pop(pop),
    .empty(empty),
    .code_point(code_point),
    .is_error(is_error),
    .is_end(is_end),
    .char_count(char_count)
  );

  always #5 clk = ~clk;

  task automatic decode_byte(input logic [7:0] b);
    u8d_pkg::result_t r;
    logic hit;
    r = '0;
    hit = 1'b0;
    if (b == 8'h00) begin
      r.is_error = !dec_skip && (dec_pending != 2'd0);
      r.is_end = 1'b1;
      r.char_count = dec_count[u8d_pkg::OUT_COUNT_BITS-1:0];
      hit = 1'b1;
      dec_partial = '0;
      dec_pending = '0;
      dec_count = '0;
      dec_skip = 1'b0;
    end else if (!dec_skip) begin
      if (dec_pending != 2'd0) begin
        dec_partial = {dec_partial[u8d_pkg::CP_BITS-7:0], b[5:0]};
        dec_pending = dec_pending - 2'd1;
        if (dec_pending == 2'd0) begin
          if (dec_count != COUNT_MAX) dec_count = dec_count + COUNT_ONE;
          r.code_point = dec_partial;
          r.char_count = dec_count[u8d_pkg::OUT_COUNT_BITS-1:0];
          hit = 1'b1;
          dec_partial = '0;
        end
      end else if (!b[7]) begin
        if (dec_count != COUNT_MAX) dec_count = dec_count + COUNT_ONE;
        r.code_point = {13'd0, b};
        r.char_count = dec_count[u8d_pkg::OUT_COUNT_BITS-1:0];
        hit = 1'b1;
      end else if (!b[5]) begin
        dec_partial = {16'd0, b[4:0]};
        dec_pending = 2'd1;
      end else if (!b[4]) begin
        dec_partial = {17'd0, b[3:0]};
        dec_pending = 2'd2;
      end else if (!b[3]) begin
        dec_partial = {18'd0, b[2:0]};
        dec_pending = 2'd3;
      end else begin
        // Invalid lead: report once, then drop everything up to the terminator.
        dec_skip = 1'b1;
        dec_partial = '0;
        r.is_error = 1'b1;
        r.char_count = dec_count[u8d_pkg::OUT_COUNT_BITS-1:0];
        hit = 1'b1;
      end
    end
    if (hit) decoded_q.push_back(r);
  endtask

  function automatic void report_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Sender side: offer the next pending byte unless idling.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      in_byte <= 8'h00;
    end else begin
      if (push && !full) decode_byte(in_byte);
      if (!(push && full)) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push <= 1'b1;
          in_byte <= pend_q.pop_front();
        end else begin
          push <= 1'b0;
          in_byte <= 8'($urandom);
        end
      end
    end
  end

  // Receiver side: check each popped result and decide on the next pop.
  always @(posedge clk) begin
    u8d_pkg::result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, actual cp=%0h err=%b end=%b count=%0d",
                   $time, code_point, is_error, is_end, char_count);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          report_field("code_point", 32'(want.code_point), 32'(code_point));
          report_field("is_error", 32'(want.is_error), 32'(is_error));
          report_field("is_end", 32'(want.is_end), 32'(is_end));
          report_field("char_count", 32'(want.char_count), 32'(char_count));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        pop <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] lead_byte(input int len);
    case (len)
      1: return {1'b1, 1'($urandom), 1'b0, 5'($urandom)};
      2: return {1'b1, 1'($urandom), 2'b10, 4'($urandom)};
      default: return {1'b1, 1'($urandom), 3'b110, 3'($urandom)};
    endcase
  endfunction

  // Mostly proper continuation bytes, sometimes any nonzero byte.
  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) != 0) return {2'b10, 6'($urandom)};
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    pend_q.push_back(b);
    gen_count++;
  endtask

  task automatic gen_string();
    int n_chars;
    int pick;
    int len;
    int cut;
    int k;
    int j;
    n_chars = $urandom_range(0, 12);
    for (k = 0; k < n_chars; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_byte(8'($urandom_range(1, 127)));
      end else if (pick < 88) begin
        len = (pick < 60) ? 1 : (pick < 75) ? 2 : 3;
        queue_byte(lead_byte(len));
        for (j = 0; j < len; j++) queue_byte(cont_byte());
      end else if (pick < 94) begin
        // Sequence cut short by the terminator.
        len = $urandom_range(1, 3);
        cut = $urandom_range(0, len - 1);
        queue_byte(lead_byte(len));
        for (j = 0; j < cut; j++) queue_byte(cont_byte());
        break;
      end else begin
        queue_byte({1'b1, 1'($urandom), 3'b111, 3'($urandom)});
        repeat ($urandom_range(0, 4)) pend_q.push_back(8'($urandom_range(1, 255)));
        break;
      end
    end
    queue_byte(8'h00);
  endtask

  task automatic wait_sent();
    while (pend_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int idle, input int stall);
    int target;
    send_idle_pct = idle;
    stall_pct = stall;
    target = gen_count + PHASE_BYTES;
    while (gen_count < target) gen_string();
    wait_sent();
  endtask

  initial begin
    logic [7:0] directed [DIRECTED_BYTES];
    int k;
    directed = '{
      8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
      8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00,
      8'hC2, 8'h41, 8'h80, 8'hBF, 8'hA0, 8'h80, 8'h80, 8'hE2, 8'h82, 8'h00,
      8'hF8, 8'h41, 8'hC3, 8'h00, 8'hFF, 8'h00, 8'hB8, 8'h00, 8'h00
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIRECTED_BYTES; k++) pend_q.push_back(directed[k]);
    wait_sent();

    random_phase(0, 0);
    random_phase(60, 0);
    random_phase(0, 60);
    random_phase(25, 25);

    // Receiver holds off while the sender keeps requesting, so the block fills.
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req <= hold_req + 1;
    @(posedge clk);
    for (k = 0; k < 6; k++) gen_string();
    wait_sent();

    while (pend_q.size() != 0 || push || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
